@@ rtl/dprc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dprc_pkg: shared types and constants for the dense PageRank column update
// Payload structs, sequencer encodings and the fixed field widths.
// ----------------------------------------------------------------------------
package dprc_pkg;

  localparam int RANK_W      = 32;
  localparam int DEG_W       = 16;
  localparam int SUM_W       = 48;
  localparam int ACC_W       = 64;
  localparam int OPND_W      = 24;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int TELE_W      = 33;
  localparam int DIV_STEPS   = 48;
  localparam int DIV_CNT_W   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING_FACTOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_WEIGHTS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_PERSONAL   = 3'd3;

  localparam logic [15:0] DAMPING_RESET      = 16'd55706;
  localparam logic [10:0] VERTEX_COUNT_RESET = 11'd1024;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [9:0]  source_index;
    logic [31:0] old_rank;
    logic [15:0] out_degree;
    logic [7:0]  edge_count;
    logic [23:0] edge_weight;
    logic [31:0] personal_value;
    logic        last_in_column;
  } item_t;

  typedef struct packed {
    logic [9:0]  column_index;
    logic [31:0] new_rank;
  } result_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic high;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_WAIT,
    S_MUL_TAKE,
    S_DIV_WAIT,
    S_ACCUM,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_COUNT_RANK,
    OP_WEIGHT,
    OP_DAMP,
    OP_PERSONAL
  } mul_op_t;

endpackage
`default_nettype wire

@@ rtl/dprc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dprc_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dprc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/dprc_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dprc_mac: shared 24x24 multiplier with shifted accumulate
// Products are registered, then added into a 64-bit accumulator in the next cycle.
// ----------------------------------------------------------------------------
module dprc_mac (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dprc_pkg::mac_ctrl_t       ctrl,
  input  wire logic [dprc_pkg::OPND_W-1:0] a,
  input  wire logic [dprc_pkg::OPND_W-1:0] b,
  output logic      [dprc_pkg::ACC_W-1:0]  acc
);
  import dprc_pkg::*;

  logic [PROD_W-1:0] prod;
  logic              prod_valid;
  logic              prod_first;
  logic              prod_high;
  logic [ACC_W-1:0]  shifted;

  // A high partial product sits one operand width further up.
  assign shifted = prod_high ? ACC_W'({prod, {OPND_W{1'b0}}}) : ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
      prod_high  <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
      prod_first <= ctrl.first;
      prod_high  <= ctrl.high;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= a * b;
    end
    if (prod_valid) begin
      acc <= prod_first ? shifted : acc + shifted;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dprc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dprc_div: restoring radix-2 divider
// Divides a 48-bit dividend by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dprc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [dprc_pkg::SUM_W-1:0] dividend,
  input  wire logic [dprc_pkg::DEG_W-1:0] divisor,
  output logic                            done,
  output logic      [dprc_pkg::SUM_W-1:0] quotient
);
  import dprc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DEG_W-1:0]     rem;
  logic [DEG_W-1:0]     divisor_q;
  logic [DEG_W:0]       rem_sh;
  logic [DEG_W:0]       rem_diff;
  logic                 fits;

  // The quotient register doubles as the dividend shifter.
  assign rem_sh   = {rem, quotient[SUM_W-1]};
  assign fits     = rem_sh >= {1'b0, divisor_q};
  assign rem_diff = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? rem_diff[DEG_W-1:0] : rem_sh[DEG_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/dense_pagerank_column_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dense_pagerank_column_update: one PageRank iteration over a dense column
// Load requests fill the rank and degree store; element requests accumulate
// edge_count * rank (times weight) / out_degree, and the last element of a
// column emits d * sum + teleport, saturated to Q2.30.
//
// Usage:
//   item channel (item_valid / item_stall / item): a request is taken when
//   item_valid is high and item_stall is low. After a load the next request
//   can follow right away. An element request keeps item_stall high while
//   the sequencer works: a multiply, a division unless the out-degree is
//   zero, and a weight multiply when weights are enabled. A last element adds
//   the damping product, the teleport term (a product for personal, a
//   division for uniform) and a step to register the result.
//   The sequencer shares one radix-2 divider (48 steps) and one 24x24
//   multiplier, which takes two partial products per operation.
//   result channel (result_valid / result_stall / result): the output register
//   holds a result until it is taken; the block keeps taking requests while
//   it waits, and only a second result stalls the sequencer.
//   cfg channel: cfg_ready is always high; write only while idle.
//   Reset clears the column sum and counter and the result valid flag, loads
//   config defaults and holds item_stall high; the stores start undefined.
// ----------------------------------------------------------------------------
module dense_pagerank_column_update #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_COLUMNS  = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire dprc_pkg::item_t                  item,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output dprc_pkg::result_t                     result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dprc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dprc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dprc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int MW = RANK_W + DEG_W;

  state_t state, state_next;
  mul_op_t mul_op;

  logic [15:0] damping_factor;
  logic [10:0] vertex_count;
  logic        use_weights;
  logic        use_personal;

  logic [7:0]  count;
  logic [23:0] weight;
  logic [31:0] personal;
  logic        last;

  logic [SUM_W-1:0]  term;
  logic [TELE_W-1:0] tele;
  logic [SUM_W-1:0]  column_sum;
  logic [CW-1:0]     column_counter;

  logic              item_accept;
  logic              src_ok;
  logic [MW-1:0]     store_rdata;
  logic [RANK_W-1:0] rank;
  logic [DEG_W-1:0]  degree;
  logic              deg_nz;

  mac_ctrl_t         mac_ctrl;
  logic [OPND_W-1:0] mac_a;
  logic [OPND_W-1:0] mac_b;
  logic [ACC_W-1:0]  acc;

  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_dividend;
  logic [DEG_W-1:0]  div_divisor;
  logic [SUM_W-1:0]  quotient;

  logic              take_to_div;
  logic [16:0]       one_minus;
  logic [10:0]       n_eff;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W:0]    total;
  logic [31:0]       new_rank;
  logic              emit_go;

  assign cfg_ready   = 1'b1;
  assign item_accept = item_valid && !item_stall;
  assign src_ok      = {22'b0, item.source_index} < 32'(MAX_VERTICES);
  assign rank        = store_rdata[RANK_W-1:0];
  assign degree      = store_rdata[MW-1:RANK_W];
  assign deg_nz      = degree != '0;
  assign one_minus   = 17'h10000 - {1'b0, damping_factor};
  assign n_eff       = (vertex_count == '0) ? 11'd1 : vertex_count;
  assign sum_add     = {1'b0, column_sum} + {1'b0, term};
  assign total       = {1'b0, term} + (SUM_W + 1)'(tele);
  assign new_rank    = (total[SUM_W:32] != '0) ? 32'hFFFF_FFFF : total[31:0];
  assign emit_go     = !result_valid || !result_stall;

  dprc_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (item_accept && item.kind == KIND_LOAD && src_ok),
    .waddr (AW'(item.source_index)),
    .wdata ({item.out_degree, item.old_rank}),
    .re    (item_accept && item.kind == KIND_ELEMENT),
    .raddr (AW'(item.source_index)),
    .rdata (store_rdata)
  );

  dprc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  dprc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Where the finished product goes next.
  always_comb begin
    case (mul_op)
      OP_COUNT_RANK: take_to_div = !use_weights && deg_nz;
      OP_WEIGHT:     take_to_div = deg_nz;
      OP_DAMP:       take_to_div = !use_personal;
      default:       take_to_div = 1'b0;
    endcase
  end

  always_comb begin
    case (mul_op)
      OP_COUNT_RANK: div_dividend = acc[SUM_W-1:0];
      OP_WEIGHT:     div_dividend = acc[ACC_W-1:16];
      default:       div_dividend = {17'b0, one_minus, 14'b0};
    endcase
    div_divisor = (mul_op == OP_DAMP) ? {5'b0, n_eff} : degree;
  end

  // Partial-product operands: the low state takes the low 24 bits of the wide
  // operand, the high state takes the rest.
  always_comb begin
    case (mul_op)
      OP_COUNT_RANK: begin
        mac_a = (state == S_MUL_HI) ? OPND_W'(rank[31:24]) : rank[23:0];
        mac_b = OPND_W'(count);
      end
      OP_WEIGHT: begin
        mac_a = (state == S_MUL_HI) ? OPND_W'(term[39:24]) : term[23:0];
        mac_b = weight;
      end
      OP_DAMP: begin
        mac_a = (state == S_MUL_HI) ? column_sum[47:24] : column_sum[23:0];
        mac_b = OPND_W'(damping_factor);
      end
      default: begin
        mac_a = (state == S_MUL_HI) ? OPND_W'(personal[31:24]) : personal[23:0];
        mac_b = OPND_W'(one_minus);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_accept && item.kind == KIND_ELEMENT) begin
          state_next = src_ok ? S_MUL_LO : S_ACCUM;
        end
      end
      S_MUL_LO:   state_next = S_MUL_HI;
      S_MUL_HI:   state_next = S_MUL_WAIT;
      S_MUL_WAIT: state_next = S_MUL_TAKE;
      S_MUL_TAKE: begin
        if (take_to_div) begin
          state_next = S_DIV_WAIT;
        end else begin
          case (mul_op)
            OP_COUNT_RANK: state_next = use_weights ? S_MUL_LO : S_ACCUM;
            OP_WEIGHT:     state_next = S_ACCUM;
            OP_DAMP:       state_next = S_MUL_LO;
            default:       state_next = S_EMIT;
          endcase
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = (mul_op == OP_DAMP) ? S_EMIT : S_ACCUM;
        end
      end
      S_ACCUM: state_next = last ? S_MUL_LO : S_IDLE;
      S_EMIT: begin
        if (emit_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall     = (state != S_IDLE) || rst;
    mac_ctrl.issue = (state == S_MUL_LO) || (state == S_MUL_HI);
    mac_ctrl.first = state == S_MUL_LO;
    mac_ctrl.high  = state == S_MUL_HI;
    div_start      = (state == S_MUL_TAKE) && take_to_div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state, configuration, accumulator, column counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_op         <= OP_COUNT_RANK;
      damping_factor <= DAMPING_RESET;
      vertex_count   <= VERTEX_COUNT_RESET;
      use_weights    <= 1'b0;
      use_personal   <= 1'b0;
      column_sum     <= '0;
      column_counter <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DAMPING_FACTOR: damping_factor <= cfg_data[15:0];
          CFG_VERTEX_COUNT:   vertex_count   <= cfg_data[10:0];
          CFG_USE_WEIGHTS:    use_weights    <= cfg_data[0];
          CFG_USE_PERSONAL:   use_personal   <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == S_EMIT && emit_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_accept && item.kind == KIND_ELEMENT) begin
            mul_op <= OP_COUNT_RANK;
          end
        end
        S_MUL_TAKE: begin
          if (mul_op == OP_COUNT_RANK && use_weights) begin
            mul_op <= OP_WEIGHT;
          end else if (mul_op == OP_DAMP && use_personal) begin
            mul_op <= OP_PERSONAL;
          end
        end
        S_ACCUM: begin
          column_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          if (last) begin
            mul_op <= OP_DAMP;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            column_sum <= '0;
            if (column_counter == CW'(MAX_COLUMNS - 1)) begin
              column_counter <= '0;
            end else begin
              column_counter <= column_counter + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Request payload, intermediate values and the result register.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_accept) begin
          count    <= item.edge_count;
          weight   <= item.edge_weight;
          personal <= item.personal_value;
          last     <= item.last_in_column;
          term     <= '0;
        end
      end
      S_MUL_TAKE: begin
        case (mul_op)
          OP_COUNT_RANK: term <= acc[SUM_W-1:0];
          OP_WEIGHT:     term <= acc[ACC_W-1:16];
          OP_DAMP:       term <= acc[ACC_W-1:16];
          default:       tele <= acc[48:16];
        endcase
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (mul_op == OP_DAMP) begin
            tele <= quotient[TELE_W-1:0];
          end else begin
            term <= quotient;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          result.column_index <= 10'(column_counter);
          result.new_rank     <= new_rank;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
